@@ src/pbd_pkg.sv @@
// Shared constants and codes of the point to box distance query.
`default_nettype none
package pbd_pkg;

  localparam int COORD_BITS_DEF = 24;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

  localparam logic [1:0] VERDICT_FAR    = 2'd0;
  localparam logic [1:0] VERDICT_NEAR   = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE = 2'd2;

  localparam logic [2:0] FACE_NONE    = 3'd0;
  localparam logic [2:0] FACE_X_ABOVE = 3'd1;
  localparam logic [2:0] FACE_Z_ABOVE = 3'd2;
  localparam logic [2:0] FACE_X_BELOW = 3'd3;
  localparam logic [2:0] FACE_Y_BELOW = 3'd4;
  localparam logic [2:0] FACE_Y_ABOVE = 3'd5;

  // Handshake control shared by every pipeline section.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

@@ src/point_box_distance_query.sv @@
// Top level of the point to axis-aligned box distance query pipeline.
// Pipeline: one clamp stage, one square stage, one sum and compare stage, and one
// stage per root bit. Throughput is one query per cycle while the output is not
// stalled; every stage holds as long as the output beat is stalled. Reset clears
// all valid bits and the six box registers to 0.
`default_nettype none
module point_box_distance_query #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Configuration write channel; always ready.
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [pbd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [COORD_BITS-1:0]           cfg_data_i,
  // Query channel.
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire signed [COORD_BITS-1:0]    point_x_i,
  input  wire signed [COORD_BITS-1:0]    point_y_i,
  input  wire signed [COORD_BITS-1:0]    point_z_i,
  input  wire        [COORD_BITS-1:0]    range_limit_i,
  // Result channel.
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic       [1:0]               verdict_o,
  output logic signed [COORD_BITS-1:0]   near_x_o,
  output logic signed [COORD_BITS-1:0]   near_y_o,
  output logic signed [COORD_BITS-1:0]   near_z_o,
  output logic       [COORD_BITS:0]      distance_o,
  output logic       [2:0]               face_code_o
);

  localparam int D      = COORD_BITS + 1;
  localparam int ROOT_W = D + 1;
  localparam int SIDE_W = 3 * COORD_BITS + 3;
  localparam int FULL_W = SIDE_W + 2;

  logic signed [COORD_BITS-1:0] box_min_q [3];
  logic signed [COORD_BITS-1:0] box_max_q [3];
  logic signed [COORD_BITS-1:0] point [3];
  pbd_pkg::pipe_ctl_t ctl_in;
  pbd_pkg::pipe_ctl_t ctl_sq;
  pbd_pkg::pipe_ctl_t ctl_rt;
  logic enable;

  logic c_valid;
  logic c_inside;
  logic signed [COORD_BITS-1:0] c_near [3];
  logic [D-1:0] c_diff [3];
  logic [2:0] c_face;
  logic [COORD_BITS-1:0] c_limit;

  logic s_valid;
  logic [1:0] s_verdict;
  logic [2*ROOT_W-1:0] s_sum;
  logic [SIDE_W-1:0] s_side;

  logic [ROOT_W-1:0] r_root;
  logic [FULL_W-1:0] r_side;

  // The whole pipeline moves together; it holds only while the final
  // result beat waits on the receiver, so no beat is lost or repeated.
  assign enable     = !(out_valid_o && out_stall_i);
  assign in_stall_o = !enable;
  assign cfg_ready_o = 1'b1;

  // Box registers. Writes beyond the sixth index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pbd_pkg::CFG_MIN_X: box_min_q[0] <= cfg_data_i;
        pbd_pkg::CFG_MIN_Y: box_min_q[1] <= cfg_data_i;
        pbd_pkg::CFG_MIN_Z: box_min_q[2] <= cfg_data_i;
        pbd_pkg::CFG_MAX_X: box_max_q[0] <= cfg_data_i;
        pbd_pkg::CFG_MAX_Y: box_max_q[1] <= cfg_data_i;
        pbd_pkg::CFG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign point[0] = point_x_i;
  assign point[1] = point_y_i;
  assign point[2] = point_z_i;

  assign ctl_in = '{en: enable, valid: in_valid_i};

  pbd_clamp #(.COORD_BITS(COORD_BITS)) u_clamp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_in),
    .box_min_i (box_min_q),
    .box_max_i (box_max_q),
    .point_i   (point),
    .limit_i   (range_limit_i),
    .valid_o   (c_valid),
    .inside_o  (c_inside),
    .near_o    (c_near),
    .diff_o    (c_diff),
    .face_o    (c_face),
    .limit_o   (c_limit)
  );

  assign ctl_sq = '{en: enable, valid: c_valid};

  // The face code of an inside point is forced to none.
  pbd_square #(.COORD_BITS(COORD_BITS), .SIDE_W(SIDE_W)) u_square (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_sq),
    .inside_i  (c_inside),
    .diff_i    (c_diff),
    .limit_i   (c_limit),
    .side_i    ({c_near[0], c_near[1], c_near[2],
                 c_inside ? pbd_pkg::FACE_NONE : c_face}),
    .valid_o   (s_valid),
    .verdict_o (s_verdict),
    .sum_o     (s_sum),
    .side_o    (s_side)
  );

  assign ctl_rt = '{en: enable, valid: s_valid};

  pbd_sqrt #(.ROOT_W(ROOT_W), .SIDE_W(FULL_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_rt),
    .sum_i   (s_sum),
    .side_i  ({s_verdict, s_side}),
    .valid_o (out_valid_o),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  // A root in range is never above the limit, so the top root bit drops.
  assign distance_o  = r_root[D-1:0];
  assign verdict_o   = r_side[FULL_W-1 -: 2];
  assign near_x_o    = r_side[3*COORD_BITS+2 -: COORD_BITS];
  assign near_y_o    = r_side[2*COORD_BITS+2 -: COORD_BITS];
  assign near_z_o    = r_side[COORD_BITS+2 -: COORD_BITS];
  assign face_code_o = r_side[2:0];

endmodule
`default_nettype wire

@@ src/pbd_clamp.sv @@
// First stage: inside test, clamp to the box, per axis distances and face code.
`default_nettype none
module pbd_clamp #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  pbd_pkg::pipe_ctl_t          ctl_i,
  input  wire signed [COORD_BITS-1:0] box_min_i [3],
  input  wire signed [COORD_BITS-1:0] box_max_i [3],
  input  wire signed [COORD_BITS-1:0] point_i [3],
  input  wire        [COORD_BITS-1:0] limit_i,
  output logic                        valid_o,
  output logic                        inside_o,
  output logic signed [COORD_BITS-1:0] near_o [3],
  output logic       [COORD_BITS:0]   diff_o [3],
  output logic       [2:0]            face_o,
  output logic       [COORD_BITS-1:0] limit_o
);

  localparam int D = COORD_BITS + 1;

  logic ge_min [3];
  logic le_max [3];
  logic signed [COORD_BITS-1:0] near_d [3];
  logic [D-1:0] diff_d [3];
  logic [2:0] face_d;
  logic inside_d;
  logic valid_q;
  logic inside_q;
  logic signed [COORD_BITS-1:0] near_q [3];
  logic [D-1:0] diff_q [3];
  logic [2:0] face_q;
  logic [COORD_BITS-1:0] limit_q;

  function automatic logic [D-1:0] sub_mag(input logic signed [COORD_BITS-1:0] a,
                                           input logic signed [COORD_BITS-1:0] b);
    logic signed [D-1:0] r;
    r = D'(a) - D'(b);
    return r;
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ge_min[a] = point_i[a] >= box_min_i[a];
      le_max[a] = point_i[a] <= box_max_i[a];
    end
    inside_d = ge_min[0] && le_max[0] && ge_min[1] && le_max[1] && ge_min[2] && le_max[2];
    face_d = pbd_pkg::FACE_NONE;
    // x axis: the upper bound is tested first.
    if (!le_max[0]) begin
      near_d[0] = box_max_i[0];
      diff_d[0] = sub_mag(point_i[0], box_max_i[0]);
      face_d    = pbd_pkg::FACE_X_ABOVE;
    end else if (!ge_min[0]) begin
      near_d[0] = box_min_i[0];
      diff_d[0] = sub_mag(box_min_i[0], point_i[0]);
      face_d    = pbd_pkg::FACE_X_BELOW;
    end else begin
      near_d[0] = point_i[0];
      diff_d[0] = '0;
    end
    // z axis: the bound tested first depends on the x outcome, which matters
    // only for an inverted box.
    if (le_max[0] && !ge_min[0]) begin
      if (!ge_min[2]) begin
        near_d[2] = box_min_i[2];
        diff_d[2] = sub_mag(box_min_i[2], point_i[2]);
      end else if (!le_max[2]) begin
        near_d[2] = box_max_i[2];
        diff_d[2] = sub_mag(point_i[2], box_max_i[2]);
      end else begin
        near_d[2] = point_i[2];
        diff_d[2] = '0;
      end
    end else begin
      if (!le_max[2]) begin
        near_d[2] = box_max_i[2];
        diff_d[2] = sub_mag(point_i[2], box_max_i[2]);
        if (le_max[0]) begin
          face_d = pbd_pkg::FACE_Z_ABOVE;
        end
      end else if (!ge_min[2]) begin
        near_d[2] = box_min_i[2];
        diff_d[2] = sub_mag(box_min_i[2], point_i[2]);
      end else begin
        near_d[2] = point_i[2];
        diff_d[2] = '0;
      end
    end
    // y axis: lower bound first, and it overrides the face code.
    if (!ge_min[1]) begin
      near_d[1] = box_min_i[1];
      diff_d[1] = sub_mag(box_min_i[1], point_i[1]);
      face_d    = pbd_pkg::FACE_Y_BELOW;
    end else if (!le_max[1]) begin
      near_d[1] = box_max_i[1];
      diff_d[1] = sub_mag(point_i[1], box_max_i[1]);
      face_d    = pbd_pkg::FACE_Y_ABOVE;
    end else begin
      near_d[1] = point_i[1];
      diff_d[1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      inside_q <= inside_d;
      near_q   <= near_d;
      diff_q   <= diff_d;
      face_q   <= face_d;
      limit_q  <= limit_i;
    end
  end

  assign valid_o  = valid_q;
  assign inside_o = inside_q;
  assign near_o   = near_q;
  assign diff_o   = diff_q;
  assign face_o   = face_q;
  assign limit_o  = limit_q;

endmodule
`default_nettype wire

@@ src/pbd_square.sv @@
// Squares of the distances and of the limit, then the exact range compare.
`default_nettype none
module pbd_square #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF,
  parameter int SIDE_W     = 3 * COORD_BITS + 3
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  pbd_pkg::pipe_ctl_t         ctl_i,
  input  wire                        inside_i,
  input  wire       [COORD_BITS:0]   diff_i [3],
  input  wire       [COORD_BITS-1:0] limit_i,
  input  wire       [SIDE_W-1:0]     side_i,
  output logic                       valid_o,
  output logic      [1:0]            verdict_o,
  output logic      [2*COORD_BITS+3:0] sum_o,
  output logic      [SIDE_W-1:0]     side_o
);

  localparam int D     = COORD_BITS + 1;
  localparam int SQ_W  = 2 * D;
  localparam int SUM_W = SQ_W + 2;

  logic              valid1_q;
  logic [SQ_W-1:0]   sq_q [3];
  logic [2*COORD_BITS-1:0] lim_sq_q;
  logic              inside1_q;
  logic [SIDE_W-1:0] side1_q;
  logic [SUM_W-1:0]  sum_d;
  logic              far_d;
  logic              valid2_q;
  logic [1:0]        verdict_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SIDE_W-1:0] side2_q;

  always_comb begin
    sum_d = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    far_d = sum_d > SUM_W'(lim_sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid1_q <= ctl_i.valid;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= diff_i[a] * diff_i[a];
      end
      lim_sq_q  <= limit_i * limit_i;
      inside1_q <= inside_i;
      side1_q   <= side_i;
      // A far query reports zero everywhere; a zero sum gives a zero root.
      if (inside1_q) begin
        verdict_q <= pbd_pkg::VERDICT_INSIDE;
        sum_q     <= sum_d;
        side2_q   <= side1_q;
      end else if (far_d) begin
        verdict_q <= pbd_pkg::VERDICT_FAR;
        sum_q     <= '0;
        side2_q   <= '0;
      end else begin
        verdict_q <= pbd_pkg::VERDICT_NEAR;
        sum_q     <= sum_d;
        side2_q   <= side1_q;
      end
    end
  end

  assign valid_o   = valid2_q;
  assign verdict_o = verdict_q;
  assign sum_o     = sum_q;
  assign side_o    = side2_q;

endmodule
`default_nettype wire

@@ src/pbd_sqrt.sv @@
// Pipelined restoring square root, one result bit per stage.
`default_nettype none
module pbd_sqrt #(
  parameter int ROOT_W = 26,
  parameter int SIDE_W = 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  pbd_pkg::pipe_ctl_t        ctl_i,
  input  wire   [2*ROOT_W-1:0]      sum_i,
  input  wire   [SIDE_W-1:0]        side_i,
  output logic                      valid_o,
  output logic  [ROOT_W-1:0]        root_o,
  output logic  [SIDE_W-1:0]        side_o
);

  localparam int SUM_W = 2 * ROOT_W;
  localparam int TW    = SUM_W + 1;

  logic [SUM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  logic [SIDE_W-1:0] side [ROOT_W+1];
  logic              vld  [ROOT_W+1];

  assign rem[0]  = sum_i;
  assign root[0] = '0;
  assign side[0] = side_i;
  assign vld[0]  = ctl_i.valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [TW-1:0]     trial;
    logic              take;
    logic [SUM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = (TW'(root[k]) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q  <= take ? rem[k] - trial[SUM_W-1:0] : rem[k];
        root_q <= take ? root[k] | (ROOT_W'(1) << B) : root[k];
        side_q <= side[k];
      end
    end

    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign side[k+1] = side_q;
    assign vld[k+1]  = vld_q;
  end

  assign valid_o = vld[ROOT_W];
  assign root_o  = root[ROOT_W];
  assign side_o  = side[ROOT_W];

endmodule
`default_nettype wire

@@ src/pbd_checker.sv @@
// Port level checks of the point to box distance query, bound to the top level.
`default_nettype none
module pbd_checker #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_stall_o,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [1:0]                    verdict_o,
  input wire [COORD_BITS-1:0]         near_x_o,
  input wire [COORD_BITS:0]           distance_o,
  input wire [2:0]                    face_code_o
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o) && $stable(verdict_o))
    else $error("stalled result beat changed");

  // The query side is held only by a waiting result beat.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("query side stalled without a waiting result");

  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == pbd_pkg::VERDICT_INSIDE |->
      distance_o == '0 && face_code_o == pbd_pkg::FACE_NONE)
    else $error("inside result with nonzero distance or face");

  a_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == pbd_pkg::VERDICT_FAR |->
      distance_o == '0 && near_x_o == '0 && face_code_o == pbd_pkg::FACE_NONE)
    else $error("far result with nonzero fields");

endmodule

bind point_box_distance_query pbd_checker #(.COORD_BITS(COORD_BITS)) u_pbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o),
  .near_x_o    (near_x_o),
  .distance_o  (distance_o),
  .face_code_o (face_code_o)
);
`default_nettype wire

@@ tb/pbd_checker.sv @@
// Result checker of the point to box distance query: predicts each beat and compares.
module pbd_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic signed [23:0]  point_x_i,
  input  logic signed [23:0]  point_y_i,
  input  logic signed [23:0]  point_z_i,
  input  logic [23:0]         range_limit_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [1:0]          verdict_i,
  input  logic signed [23:0]  near_x_i,
  input  logic signed [23:0]  near_y_i,
  input  logic signed [23:0]  near_z_i,
  input  logic [24:0]         distance_i,
  input  logic [2:0]          face_code_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [1:0]         verdict;
    logic signed [23:0] nx;
    logic signed [23:0] ny;
    logic signed [23:0] nz;
    logic [24:0]        distance;
    logic [2:0]         face;
  } answer_t;

  logic signed [23:0] box_lo [3];
  logic signed [23:0] box_hi [3];
  answer_t answers_due[$];

  function automatic logic [24:0] root_floor(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= s) r = c;
    end
    return r[24:0];
  endfunction

  // Predicts one query: inside test, then per axis clamp and gap in the order of comparisons used.
  function automatic answer_t predict_query(logic signed [23:0] px, logic signed [23:0] py,
                                            logic signed [23:0] pz, logic [23:0] lim);
    answer_t a;
    logic signed [24:0] cx, cy, cz;
    logic [25:0] dx, dy, dz;
    logic [2:0] face;
    logic [67:0] sum;
    a = '0;
    dx = 0; dy = 0; dz = 0; face = pbd_pkg::FACE_NONE;
    if (px >= box_lo[0] && px <= box_hi[0] && py >= box_lo[1] && py <= box_hi[1] &&
        pz >= box_lo[2] && pz <= box_hi[2]) begin
      a.verdict = pbd_pkg::VERDICT_INSIDE;
      a.nx = px; a.ny = py; a.nz = pz;
      return a;
    end
    // The x test picks the z comparison order, which matters for inverted boxes.
    if (px <= box_hi[0]) begin
      if (px >= box_lo[0]) begin
        cx = px;
        if (pz <= box_hi[2]) begin
          if (pz >= box_lo[2]) cz = pz;
          else begin cz = box_lo[2]; dz = 26'(box_lo[2] - pz); end
        end else begin
          cz = box_hi[2]; dz = 26'(pz - box_hi[2]); face = pbd_pkg::FACE_Z_ABOVE;
        end
      end else begin
        cx = box_lo[0]; dx = 26'(box_lo[0] - px); face = pbd_pkg::FACE_X_BELOW;
        if (pz >= box_lo[2]) begin
          if (pz <= box_hi[2]) cz = pz;
          else begin cz = box_hi[2]; dz = 26'(pz - box_hi[2]); end
        end else begin
          cz = box_lo[2]; dz = 26'(box_lo[2] - pz);
        end
      end
    end else begin
      cx = box_hi[0]; dx = 26'(px - box_hi[0]); face = pbd_pkg::FACE_X_ABOVE;
      if (pz <= box_hi[2]) begin
        if (pz >= box_lo[2]) cz = pz;
        else begin cz = box_lo[2]; dz = 26'(box_lo[2] - pz); end
      end else begin
        cz = box_hi[2]; dz = 26'(pz - box_hi[2]);
      end
    end
    if (py >= box_lo[1]) begin
      if (py <= box_hi[1]) cy = py;
      else begin
        cy = box_hi[1]; dy = 26'(py - box_hi[1]); face = pbd_pkg::FACE_Y_ABOVE;
      end
    end else begin
      cy = box_lo[1]; dy = 26'(box_lo[1] - py); face = pbd_pkg::FACE_Y_BELOW;
    end
    sum = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
    if (sum > 68'(lim) * 68'(lim)) begin
      a.verdict = pbd_pkg::VERDICT_FAR;
      return a;
    end
    a.verdict = pbd_pkg::VERDICT_NEAR;
    a.nx = cx[23:0]; a.ny = cy[23:0]; a.nz = cz[23:0];
    a.distance = root_floor(sum);
    a.face = face;
    return a;
  endfunction

  assign pending_o = answers_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        answers_due.push_back(predict_query(point_x_i, point_y_i, point_z_i, range_limit_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i < pbd_pkg::CFG_MAX_X) box_lo[cfg_index_i] <= cfg_data_i;
        else if (cfg_index_i <= pbd_pkg::CFG_MAX_Z)
          box_hi[cfg_index_i - pbd_pkg::CFG_MAX_X] <= cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{verdict_i, near_x_i, near_y_i, near_z_i, distance_i, face_code_i};
        if (answers_due.size() == 0) begin
          $error("result beat with no query outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answers_due.pop_front();
          if (got != want) begin
            if (got.verdict != want.verdict)
              $error("verdict expected %0d got %0d", want.verdict, got.verdict);
            if (got.nx != want.nx) $error("near_x expected %0d got %0d", want.nx, got.nx);
            if (got.ny != want.ny) $error("near_y expected %0d got %0d", want.ny, got.ny);
            if (got.nz != want.nz) $error("near_z expected %0d got %0d", want.nz, got.nz);
            if (got.distance != want.distance)
              $error("distance expected %0d got %0d", want.distance, got.distance);
            if (got.face != want.face)
              $error("face_code expected %0d got %0d", want.face, got.face);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_point_box_distance_query.sv @@
// Testbench top of the point to box distance query: stimulus, box settings and verdict.
module tb_point_box_distance_query;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = pbd_pkg::CFG_MIN_X;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] point_x = '0, point_y = '0, point_z = '0;
  logic [23:0] range_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] verdict;
  logic signed [23:0] near_x, near_y, near_z;
  logic [24:0] distance;
  logic [2:0] face_code;
  int fail_count;
  int pending;
  int cycle_count = 0;
  // Set while the receiver holds off for a long stretch so the pipeline fills.
  logic hold_off = 1'b0;
  logic signed [23:0] lo [3];
  logic signed [23:0] hi [3];

  always #5 clk = ~clk;

  point_box_distance_query dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .range_limit_i(range_limit),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .verdict_o(verdict), .near_x_o(near_x), .near_y_o(near_y), .near_z_o(near_z),
    .distance_o(distance), .face_code_o(face_code)
  );

  pbd_result_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .range_limit_i(range_limit),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .verdict_i(verdict), .near_x_i(near_x), .near_y_i(near_y), .near_z_i(near_z),
    .distance_i(distance), .face_code_i(face_code),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: a run that has not finished by now is treated as hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a random stall, possibly none, before each result beat, with runs of no stall and the
  // long hold-off when asked. Stall only rises once the beat is taken or absent.
  initial begin : receiver
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (cycle_count % 3000 < 600) gap = 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // Offers one register write and waits until it is taken; the caller drops valid.
  task automatic write_box_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes a whole box while the pipeline is empty and mirrors it for stimulus shaping.
  task automatic load_box(input logic signed [23:0] x0, y0, z0, x1, y1, z1);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    lo[0] = x0; lo[1] = y0; lo[2] = z0; hi[0] = x1; hi[1] = y1; hi[2] = z1;
    write_box_reg(pbd_pkg::CFG_MIN_X, x0);
    write_box_reg(pbd_pkg::CFG_MIN_Y, y0);
    write_box_reg(pbd_pkg::CFG_MIN_Z, z0);
    write_box_reg(pbd_pkg::CFG_MAX_X, x1);
    write_box_reg(pbd_pkg::CFG_MAX_Y, y1);
    write_box_reg(pbd_pkg::CFG_MAX_Z, z1);
    cfg_valid <= 1'b0;
  endtask

  // Offers one query beat; gaps are drawn per beat unless a burst is asked.
  task automatic send_query(input logic signed [23:0] x, y, z, input logic [23:0] lim,
                            input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x; point_y <= y; point_z <= z;
    range_limit <= lim;
    do @(posedge clk); while (in_stall);
  endtask

  // A coordinate near the box on one axis: inside, on a bound, just off, or anywhere.
  function automatic logic signed [23:0] pick_coord(int axis);
    logic signed [23:0] a, b;
    a = lo[axis]; b = hi[axis];
    case ($urandom_range(0, 6))
      0: return a;
      1: return b;
      2: return a - 24'($urandom_range(1, 300));
      3: return b + 24'($urandom_range(1, 300));
      4: return 24'($urandom);
      default: begin
        if (a <= b) return a + 24'($urandom_range(0, 32'(int'(b) - int'(a))));
        return 24'($urandom);
      end
    endcase
  endfunction

  function automatic logic [23:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 1000));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++)
      send_query(pick_coord(0), pick_coord(1), pick_coord(2), pick_limit(), 1'b0);
  endtask

  initial begin : stimulus
    logic signed [23:0] vmin, vmax;
    vmin = 24'sh800000;
    vmax = 24'sh7FFFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset box is the single point at the origin.
    send_query(0, 0, 0, 0, 1'b0);
    send_query(1, 0, 0, 1, 1'b0);
    load_box(-24'sd1000, -24'sd1000, -24'sd1000, 24'sd1000, 24'sd1000, 24'sd1000);
    // Inside, corner ties, each face, far, tie at the limit, extremes.
    send_query(0, 0, 0, 24'd5, 1'b0);
    send_query(-24'sd1000, 24'sd1000, -24'sd1000, 24'd0, 1'b0);
    send_query(24'sd1003, 0, 0, 24'd3, 1'b0);
    send_query(24'sd1003, 0, 0, 24'd2, 1'b0);
    send_query(-24'sd1004, 0, 0, 24'd10, 1'b0);
    send_query(0, 0, 24'sd1500, 24'd600, 1'b0);
    send_query(0, 0, -24'sd1500, 24'd600, 1'b0);
    send_query(0, 24'sd1300, 0, 24'd600, 1'b0);
    send_query(0, -24'sd1300, 0, 24'd600, 1'b0);
    send_query(24'sd1003, 24'sd1004, 24'sd1000, 24'd5, 1'b0);
    send_query(24'sd1003, 24'sd1004, 24'sd1000, 24'd4, 1'b0);
    send_query(vmax, vmax, vmax, 24'hFFFFFF, 1'b0);
    send_query(vmin, vmin, vmin, 24'hFFFFFF, 1'b0);
    send_query(vmin, vmax, vmin, 24'h000000, 1'b0);
    send_query(24'sh555555, -24'sh2AAAAA, 24'sh0F0F0F, 24'hAAAAAA, 1'b0);
    random_phase(150);

    // Full range box: everything is inside.
    load_box(vmin, vmin, vmin, vmax, vmax, vmax);
    random_phase(60);

    // Inverted box exercises the comparison order on every axis.
    load_box(24'sd500, 24'sd400, 24'sd300, -24'sd500, -24'sd400, -24'sd300);
    random_phase(150);

    // Box pinned at the most negative corner, with long hold-off on the receiver.
    load_box(vmin, vmin, vmin, vmin + 24'sd5000, vmin + 24'sd64, vmin + 24'sd900);
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++)
        send_query(pick_coord(0), pick_coord(1), pick_coord(2), pick_limit(), 1'b1);
    join
    random_phase(100);

    for (int p = 0; p < 4; p++) begin
      vmin = 24'($urandom);
      vmax = vmin + 24'($urandom_range(0, 100000));
      if (vmax < vmin) vmax = 24'sh7FFFFF;
      load_box(vmin, vmin - 24'sd7000, vmin + 24'sd77,
               vmax, vmax - 24'sd6000, vmax + 24'sd90000);
      random_phase(130);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
